// File: rtl/printer_escape_sequence_parser_assert.svh
// Assertion macros for the printer escape sequence parser.
`ifndef PRINTER_ESCAPE_SEQUENCE_PARSER_ASSERT_SVH
`define PRINTER_ESCAPE_SEQUENCE_PARSER_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define PESP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define PESP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: rtl/pesp_pkg.sv
// Types, command table and table search for the printer escape sequence parser.
package pesp_pkg;

  localparam int unsigned RowCount = 96;
  localparam int unsigned ParamLimit = 100;

  localparam logic [7:0] ESC_BYTE  = 8'h1B;
  localparam logic [7:0] PFX_BRACK = 8'h5B;
  localparam logic [7:0] PFX_SEMI  = 8'h3B;
  localparam logic [7:0] PFX_QUOTE = 8'h22;
  localparam logic [7:0] PFX_PAREN = 8'h28;
  localparam logic [7:0] PFX_HASH  = 8'h23;
  localparam logic [7:0] GRP_NONE  = 8'h00;
  localparam logic [7:0] PRM_WILD  = 8'hFF;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  typedef enum logic [1:0] {
    KIND_CONSUMED = 2'd0,
    KIND_TEXT     = 2'd1,
    KIND_CMD      = 2'd2
  } kind_e;

  // Parser position: which prefix group the current sequence is in.
  typedef enum logic [6:0] {
    GRP_IDLE  = 7'b0000001,
    GRP_ESC   = 7'b0000010,
    GRP_HASH  = 7'b0000100,
    GRP_PAREN = 7'b0001000,
    GRP_BRACK = 7'b0010000,
    GRP_QUOTE = 7'b0100000,
    GRP_SEMI  = 7'b1000000
  } grp_e;

  typedef struct packed {
    logic       hit;
    logic [6:0] row;
  } match_t;

  localparam logic [7:0] ROM_GRP [RowCount] = '{
    GRP_NONE,
    ESC_BYTE, ESC_BYTE, ESC_BYTE, ESC_BYTE, ESC_BYTE, ESC_BYTE, ESC_BYTE, ESC_BYTE,
    PFX_HASH, PFX_HASH, PFX_HASH, PFX_HASH, PFX_HASH, PFX_HASH, PFX_HASH, PFX_HASH,
    PFX_PAREN, PFX_PAREN, PFX_PAREN, PFX_PAREN, PFX_PAREN, PFX_PAREN, PFX_PAREN,
    PFX_PAREN, PFX_PAREN, PFX_PAREN, PFX_PAREN,
    PFX_BRACK,
    PFX_BRACK, PFX_BRACK, PFX_BRACK, PFX_BRACK, PFX_BRACK, PFX_BRACK,
    PFX_BRACK, PFX_BRACK, PFX_BRACK, PFX_BRACK,
    PFX_BRACK, PFX_BRACK, PFX_BRACK, PFX_BRACK, PFX_BRACK, PFX_BRACK,
    PFX_BRACK, PFX_BRACK, PFX_BRACK, PFX_BRACK, PFX_BRACK,
    PFX_BRACK, PFX_BRACK, PFX_BRACK, PFX_BRACK, PFX_BRACK,
    PFX_BRACK,
    PFX_BRACK, PFX_BRACK, PFX_BRACK, PFX_BRACK, PFX_BRACK,
    PFX_BRACK, PFX_BRACK, PFX_BRACK, PFX_BRACK, PFX_BRACK,
    PFX_BRACK, PFX_BRACK, PFX_BRACK,
    PFX_BRACK, PFX_BRACK,
    PFX_BRACK,
    PFX_BRACK, PFX_BRACK, PFX_BRACK, PFX_BRACK, PFX_BRACK,
    PFX_BRACK, PFX_BRACK, PFX_BRACK, PFX_BRACK, PFX_BRACK, PFX_BRACK, PFX_BRACK,
    PFX_BRACK, PFX_BRACK,
    PFX_QUOTE, PFX_QUOTE, PFX_QUOTE, PFX_QUOTE, PFX_QUOTE, PFX_QUOTE, PFX_QUOTE,
    PFX_QUOTE,
    PFX_SEMI, PFX_SEMI
  };

  localparam logic [7:0] ROM_CODE [RowCount] = '{
    8'h00,
    8'h44, 8'h45, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h63,
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h38, 8'h39,
    8'h36, 8'h41, 8'h42, 8'h43, 8'h45, 8'h48, 8'h4A,
    8'h4B, 8'h52, 8'h59, 8'h5A,
    8'h45,
    8'h46, 8'h46, 8'h46, 8'h46, 8'h46, 8'h46,
    8'h67, 8'h67, 8'h67, 8'h67,
    8'h6D, 8'h6D, 8'h6D, 8'h6D, 8'h6D, 8'h6D,
    8'h6D, 8'h6D, 8'h6D, 8'h6D, 8'h6D,
    8'h6D, 8'h6D, 8'h6D, 8'h6D, 8'h6D,
    8'h6D,
    8'h6D, 8'h6D, 8'h6D, 8'h6D, 8'h6D,
    8'h6D, 8'h6D, 8'h6D, 8'h6D, 8'h6D,
    8'h70, 8'h70, 8'h70,
    8'h71, 8'h71,
    8'h74,
    8'h76, 8'h76, 8'h76, 8'h76, 8'h76,
    8'h77, 8'h77, 8'h77, 8'h77, 8'h77, 8'h77, 8'h77,
    8'h7A, 8'h7A,
    8'h72, 8'h78, 8'h7A, 8'h7A, 8'h7A, 8'h7A, 8'h7A, 8'h7A,
    8'h72, 8'h73
  };

  localparam logic [7:0] ROM_PRM [RowCount] = '{
    PRM_WILD,
    PRM_WILD, PRM_WILD, PRM_WILD, PRM_WILD, PRM_WILD, PRM_WILD, PRM_WILD, PRM_WILD,
    PRM_WILD, PRM_WILD, PRM_WILD, PRM_WILD, PRM_WILD, PRM_WILD, PRM_WILD, PRM_WILD,
    PRM_WILD, PRM_WILD, PRM_WILD, PRM_WILD, PRM_WILD, PRM_WILD, PRM_WILD,
    PRM_WILD, PRM_WILD, PRM_WILD, PRM_WILD,
    PRM_WILD,
    8'd0, 8'd1, 8'd3, 8'd5, 8'd6, 8'd7,
    8'd0, 8'd1, 8'd3, 8'd4,
    8'd0, 8'd1, 8'd22, 8'd23, 8'd24, 8'd3,
    8'd30, 8'd31, 8'd32, 8'd33, 8'd34,
    8'd35, 8'd36, 8'd37, 8'd38, 8'd39,
    8'd4,
    8'd40, 8'd41, 8'd42, 8'd43, 8'd44,
    8'd45, 8'd46, 8'd47, 8'd48, 8'd49,
    8'd0, 8'd1, 8'd2,
    PRM_WILD, 8'd0,
    PRM_WILD,
    8'd0, 8'd1, 8'd2, 8'd3, 8'd4,
    8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6,
    8'd0, 8'd1,
    PRM_WILD, PRM_WILD, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6,
    PRM_WILD, PRM_WILD
  };

  // Group byte that the table uses for each parser position.
  function automatic logic [7:0] grp_byte(grp_e grp);
    logic [7:0] b;
    case (grp)
      GRP_ESC:   b = ESC_BYTE;
      GRP_HASH:  b = PFX_HASH;
      GRP_PAREN: b = PFX_PAREN;
      GRP_BRACK: b = PFX_BRACK;
      GRP_QUOTE: b = PFX_QUOTE;
      GRP_SEMI:  b = PFX_SEMI;
      default:   b = GRP_NONE;
    endcase
    return b;
  endfunction

  // First row of the group with this code whose parameter is a wildcard or
  // equals the first parameter. Rows that share a code sit next to each other,
  // so the lowest such row is the one a linear walk would stop at.
  function automatic match_t rom_match(logic [7:0] grp, logic [7:0] code,
                                       logic [6:0] prm);
    match_t     m;
    logic [6:0] ri;
    m.hit = 1'b0;
    m.row = '0;
    for (int r = RowCount - 1; r > 0; r--) begin
      ri = 7'(r);
      if (ROM_GRP[ri] == grp && ROM_CODE[ri] == code &&
          (ROM_PRM[ri] == PRM_WILD || ROM_PRM[ri] == {1'b0, prm})) begin
        m.hit = 1'b1;
        m.row = ri;
      end
    end
    return m;
  endfunction

endpackage

// File: rtl/printer_escape_sequence_parser.sv
// Top level of the printer escape sequence parser.
//
// The block takes one byte of a text stream per word on the input channel
// (in_valid_i / in_ready_o / data_byte_i) and gives exactly one result word per
// input byte on the output channel (out_valid_o / out_ready_i). A result says
// whether the byte was consumed inside an escape sequence, passes through as
// plain text (text_byte_o), or completed a command (command_row_o with
// param_first_o and param_second_o). Fields that do not apply to a result are
// zero.
//
// A byte accepted at one edge has its result in the output register from the
// next cycle on. Throughput is one byte per cycle while the receiver keeps up;
// the table search is a single pass of row compares between the parser state
// and the output register. The output register is the only stage, so a new
// byte is taken whenever that register is empty or is being read in the same
// cycle. While the receiver stalls, the result holds and in_ready_o is low.
//
// Reset puts the parser in the idle position with both parameters and the
// parameter slot cleared, and empties the output register.
module printer_escape_sequence_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] text_byte_o,
  output logic [6:0] command_row_o,
  output logic [6:0] param_first_o,
  output logic [6:0] param_second_o
);
  import pesp_pkg::*;

  grp_e       grp_q, grp_d;
  logic [6:0] pv0_q, pv0_d;
  logic [6:0] pv1_q, pv1_d;
  logic       slot_q, slot_d;

  logic       out_valid_q;
  kind_e      kind_q, kind_d;
  logic [7:0] text_q, text_d;
  logic [6:0] row_q, row_d;
  logic [6:0] pf_q, pf_d;
  logic [6:0] ps_q, ps_d;

  logic       accept;
  logic       is_digit;
  logic       param_grp;
  logic [3:0] digit;
  logic [6:0] pcur;
  logic [9:0] pnew;
  match_t     match;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign is_digit  = (data_byte_i >= CHAR_ZERO) && (data_byte_i <= CHAR_NINE);
  assign param_grp = (grp_q == GRP_BRACK) || (grp_q == GRP_QUOTE) || (grp_q == GRP_SEMI);
  assign digit     = 4'(data_byte_i - CHAR_ZERO);
  assign pcur      = slot_q ? pv1_q : pv0_q;
  // Times ten as two shifts; the worst case 100 * 10 + 9 fits in ten bits.
  assign pnew      = ({3'b000, pcur} << 3) + ({3'b000, pcur} << 1) + {6'b0, digit};
  assign match     = rom_match(grp_byte(grp_q), data_byte_i, pv0_q);

  always_comb begin
    grp_d  = grp_q;
    pv0_d  = pv0_q;
    pv1_d  = pv1_q;
    slot_d = slot_q;
    kind_d = KIND_CONSUMED;
    text_d = '0;
    row_d  = '0;
    pf_d   = '0;
    ps_d   = '0;
    case (grp_q)
      GRP_IDLE: begin
        if (data_byte_i == ESC_BYTE) begin
          grp_d  = GRP_ESC;
          pv0_d  = '0;
          pv1_d  = '0;
          slot_d = 1'b0;
        end else begin
          kind_d = KIND_TEXT;
          text_d = data_byte_i;
        end
      end
      default: begin
        if (param_grp && is_digit) begin
          if (pnew > 10'(ParamLimit)) begin
            grp_d  = GRP_IDLE;
            kind_d = KIND_TEXT;
            text_d = data_byte_i;
          end else if (slot_q) begin
            pv1_d = pnew[6:0];
          end else begin
            pv0_d = pnew[6:0];
          end
        end else if (grp_q == GRP_ESC && data_byte_i == PFX_HASH) begin
          grp_d = GRP_HASH;
        end else if (grp_q == GRP_ESC && data_byte_i == PFX_PAREN) begin
          grp_d = GRP_PAREN;
        end else if (grp_q == GRP_ESC && data_byte_i == PFX_BRACK) begin
          grp_d = GRP_BRACK;
        end else if (grp_q == GRP_BRACK && data_byte_i == PFX_QUOTE) begin
          grp_d = GRP_QUOTE;
        end else if (grp_q == GRP_BRACK && data_byte_i == PFX_SEMI) begin
          grp_d  = GRP_SEMI;
          slot_d = 1'b1;
          pv1_d  = '0;
        end else if (match.hit) begin
          grp_d  = GRP_IDLE;
          kind_d = KIND_CMD;
          row_d  = match.row;
          pf_d   = pv0_q;
          ps_d   = pv1_q;
        end else begin
          // Unknown code or no row with a fitting parameter: drop the sequence.
          grp_d  = GRP_IDLE;
          kind_d = KIND_TEXT;
          text_d = data_byte_i;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q       <= GRP_IDLE;
      pv0_q       <= '0;
      pv1_q       <= '0;
      slot_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        grp_q  <= grp_d;
        pv0_q  <= pv0_d;
        pv1_q  <= pv1_d;
        slot_q <= slot_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_d;
      text_q <= text_d;
      row_q  <= row_d;
      pf_q   <= pf_d;
      ps_q   <= ps_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign text_byte_o    = text_q;
  assign command_row_o  = row_q;
  assign param_first_o  = pf_q;
  assign param_second_o = ps_q;

`include "printer_escape_sequence_parser_assert.svh"

  `PESP_ASSERT(a_idle_text, accept && grp_q == GRP_IDLE && data_byte_i != ESC_BYTE |=> out_valid_o && kind_o == KIND_TEXT && text_byte_o == $past(data_byte_i), "idle non-ESC byte did not pass as text")
  `PESP_ASSERT(a_end_idle, accept && kind_d != KIND_CONSUMED |=> grp_q == GRP_IDLE, "parser not idle after a text or command result")
  `PESP_ASSERT(a_cmd_row, out_valid_o && kind_o == KIND_CMD |-> command_row_o != 7'd0 && command_row_o < 7'(RowCount) && text_byte_o == 8'd0, "command result with a bad row")
  `PESP_ASSERT(a_param_range, pv0_q <= 7'(ParamLimit) && pv1_q <= 7'(ParamLimit), "parameter above its limit")

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the printer escape sequence parser.
`timescale 1ns / 1ps

module tb_top;
  import pesp_pkg::*;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] text;
    logic [6:0] row;
    logic [6:0] param1;
    logic [6:0] param2;
  } parse_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] kind;
  logic [6:0] command_row;
  logic [7:0] text_byte;
  logic [6:0] param_first;
  logic [6:0] param_second;

  // Command table, rebuilt here from the printer's command list.
  logic [7:0]  cmd_grp  [RowCount];
  logic [7:0]  cmd_code [RowCount];
  logic [7:0]  cmd_prm  [RowCount];
  int unsigned row_fill = 0;

  // Parser state as the predictor sees it.
  int unsigned cur_row;
  logic [6:0]  prm_val [2];
  logic        prm_slot;

  logic [7:0]    stim_q [$];
  logic [7:0]    seq_q [$];
  parse_result_t expect_q [$];

  int unsigned total_items = 1;
  int unsigned accepted_cnt = 0;
  int unsigned results_seen = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  printer_escape_sequence_parser u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .data_byte_i   (data_byte),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .kind_o        (kind),
    .text_byte_o   (text_byte),
    .command_row_o (command_row),
    .param_first_o (param_first),
    .param_second_o(param_second)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic add_row(logic [7:0] g, logic [7:0] code, logic [7:0] prm);
    cmd_grp[row_fill[6:0]]  = g;
    cmd_code[row_fill[6:0]] = code;
    cmd_prm[row_fill[6:0]]  = prm;
    row_fill++;
  endtask

  task automatic add_wild_rows(logic [7:0] g, string codes);
    foreach (codes[i]) add_row(g, codes[i], PRM_WILD);
  endtask

  // One row per single-digit parameter, all with the same code.
  task automatic add_digit_rows(logic [7:0] g, logic [7:0] code, string digits);
    foreach (digits[i]) add_row(g, code, digits[i] - CHAR_ZERO);
  endtask

  function automatic parse_result_t parse_byte(logic [7:0] c);
    parse_result_t res;
    logic [7:0]    grp;
    int unsigned   r;
    int unsigned   p;
    bit            as_text;
    res = '0;
    res.kind = KIND_CONSUMED;
    as_text = 1'b0;
    grp = cmd_grp[cur_row[6:0]];
    if (grp == GRP_NONE) begin
      if (c != ESC_BYTE) begin
        as_text = 1'b1;
      end else begin
        prm_val[0] = '0;
        prm_val[1] = '0;
        prm_slot = 1'b0;
        cur_row = 1;
      end
    end else if (grp != ESC_BYTE && grp != PFX_HASH && grp != PFX_PAREN &&
                 c >= CHAR_ZERO && c <= CHAR_NINE) begin
      p = prm_val[prm_slot] * 10 + (c - CHAR_ZERO);
      if (p > ParamLimit) as_text = 1'b1;
      else prm_val[prm_slot] = p[6:0];
    end else if ((grp == ESC_BYTE && (c == PFX_HASH || c == PFX_PAREN || c == PFX_BRACK)) ||
                 (grp == PFX_BRACK && (c == PFX_SEMI || c == PFX_QUOTE))) begin
      r = cur_row;
      while (r < RowCount && cmd_grp[r[6:0]] != c) r++;
      if (r >= RowCount) begin
        as_text = 1'b1;
      end else begin
        cur_row = r;
        if (c == PFX_SEMI) begin
          prm_slot = 1'b1;
          prm_val[1] = '0;
        end
      end
    end else begin
      // Skip to the rows of this code, then take the first whose parameter fits.
      r = cur_row;
      while (r < RowCount && cmd_grp[r[6:0]] == grp && cmd_code[r[6:0]] != c) r++;
      as_text = 1'b1;
      while (as_text && r < RowCount && cmd_grp[r[6:0]] == grp && cmd_code[r[6:0]] == c) begin
        if (cmd_prm[r[6:0]] == PRM_WILD || cmd_prm[r[6:0]] == {1'b0, prm_val[0]}) begin
          as_text = 1'b0;
          cur_row = 0;
          res.kind = KIND_CMD;
          res.row = r[6:0];
          res.param1 = prm_val[0];
          res.param2 = prm_val[1];
        end
        r++;
      end
    end
    if (as_text) begin
      cur_row = 0;
      res.kind = KIND_TEXT;
      res.text = c;
    end
    return res;
  endfunction

  // Decimal digits of a parameter; zero is sometimes left out, and a leading
  // zero is sometimes added.
  task automatic push_number(int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    if (v == 0 && $urandom_range(2) == 0) return;
    if ($urandom_range(3) == 0) seq_q.push_back(CHAR_ZERO);
    foreach (s[i]) seq_q.push_back(s[i]);
  endtask

  task automatic add_random_sequence();
    int unsigned mode;
    int unsigned r;
    int unsigned pos;
    int unsigned p0;
    logic [7:0]  g;
    seq_q.delete();
    mode = $urandom_range(99);
    if (mode < 15) begin
      seq_q.push_back(8'($urandom_range(255)));
    end else if (mode >= 92) begin
      // Parameter that runs past the limit.
      seq_q.push_back(ESC_BYTE);
      seq_q.push_back(PFX_BRACK);
      if ($urandom_range(1) == 1) begin
        push_number($urandom_range(100));
        seq_q.push_back(PFX_SEMI);
      end
      push_number($urandom_range(999, 101));
      seq_q.push_back("m");
    end else begin
      r = $urandom_range(RowCount - 1, 1);
      g = cmd_grp[r[6:0]];
      p0 = (cmd_prm[r[6:0]] == PRM_WILD) ? $urandom_range(100) : cmd_prm[r[6:0]];
      seq_q.push_back(ESC_BYTE);
      if (g == PFX_HASH || g == PFX_PAREN) begin
        seq_q.push_back(g);
      end else if (g != ESC_BYTE) begin
        seq_q.push_back(PFX_BRACK);
        if (g == PFX_QUOTE && $urandom_range(1) == 1) begin
          seq_q.push_back(PFX_QUOTE);
          push_number(p0);
        end else begin
          push_number(p0);
          if (g != PFX_BRACK) seq_q.push_back(g);
          if (g == PFX_SEMI) push_number($urandom_range(100));
        end
      end
      seq_q.push_back(cmd_code[r[6:0]]);
      pos = $urandom_range(seq_q.size() - 1, 1);
      if (mode >= 85) begin
        while (seq_q.size() > pos) void'(seq_q.pop_back());
        seq_q.push_back(8'($urandom_range(255)));
      end else if (mode >= 75) begin
        seq_q[pos] = 8'($urandom_range(255));
      end
    end
    foreach (seq_q[i]) stim_q.push_back(seq_q[i]);
  endtask

  function automatic int unsigned idle_pct(int unsigned done_cnt, bit sender);
    int unsigned phase;
    phase = done_cnt * 3 / total_items;
    if (phase == 0) return sender ? 8 : 88;
    if (phase == 1) return sender ? 88 : 8;
    return 0;
  endfunction

  initial begin
    add_row(GRP_NONE, 8'h00, PRM_WILD);
    add_wild_rows(ESC_BYTE, "DEHJKLMc");
    add_wild_rows(PFX_HASH, "01234589");
    add_wild_rows(PFX_PAREN, "6ABCEHJKRYZ");
    add_wild_rows(PFX_BRACK, "E");
    add_digit_rows(PFX_BRACK, "F", "013567");
    add_digit_rows(PFX_BRACK, "g", "0134");
    add_digit_rows(PFX_BRACK, "m", "01");
    for (int k = 22; k <= 24; k++) add_row(PFX_BRACK, "m", 8'(k));
    add_row(PFX_BRACK, "m", 8'd3);
    for (int k = 30; k <= 39; k++) add_row(PFX_BRACK, "m", 8'(k));
    add_row(PFX_BRACK, "m", 8'd4);
    for (int k = 40; k <= 49; k++) add_row(PFX_BRACK, "m", 8'(k));
    add_digit_rows(PFX_BRACK, "p", "012");
    add_row(PFX_BRACK, "q", PRM_WILD);
    add_row(PFX_BRACK, "q", 8'd0);
    add_wild_rows(PFX_BRACK, "t");
    add_digit_rows(PFX_BRACK, "v", "01234");
    add_digit_rows(PFX_BRACK, "w", "0123456");
    add_digit_rows(PFX_BRACK, "z", "01");
    add_wild_rows(PFX_QUOTE, "rx");
    add_digit_rows(PFX_QUOTE, "z", "123456");
    add_wild_rows(PFX_SEMI, "rs");

    // Directed words: byte extremes, digit codes after '#' and '(', both
    // parameters at the limit, a parameter overflow and ESC inside a sequence.
    stim_q = '{8'h00, 8'hFF, ESC_BYTE, "#", "9", ESC_BYTE, "(", "6",
               ESC_BYTE, "[", "1", "0", "0", ";", "1", "0", "0", "s",
               ESC_BYTE, "[", "1", "0", "1", ESC_BYTE, ESC_BYTE};
    r_loop: while (stim_q.size() < 825) add_random_sequence();
    total_items = stim_q.size();

    cur_row = 0;
    prm_val[0] = '0;
    prm_val[1] = '0;
    prm_slot = 1'b0;
    foreach (stim_q[i]) expect_q.push_back(parse_byte(stim_q[i]));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (expect_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) accepted_cnt <= accepted_cnt + 1;
      if (!in_valid || in_ready) begin
        if (stim_q.size() != 0 && $urandom_range(99) >= idle_pct(accepted_cnt, 1'b1)) begin
          in_valid <= 1'b1;
          data_byte <= stim_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Late in the run the receiver stops for a long stretch so that the
  // output word backs up and the input stalls.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && accepted_cnt >= total_items * 5 / 6) begin
        hold_left <= 300;
        hold_done <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_ready <= (hold_left == 0) &&
                   ($urandom_range(99) >= idle_pct(results_seen, 1'b0));
    end
  end

  always @(posedge clk_i) begin
    parse_result_t want;
    if (rst_ni && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (results_seen >= accepted_cnt || expect_q.size() == 0) begin
        if (mismatch_cnt < 10)
          $display("%0t: result word %0d arrived with no byte pending", $realtime,
                   results_seen);
        mismatch_cnt++;
      end else begin
        want = expect_q.pop_front();
        if ({kind, text_byte, command_row, param_first, param_second} !== want) begin
          if (mismatch_cnt < 10)
            $display({"%0t: result word %0d: expected kind %0d text %02h row %0d ",
                      "params %0d %0d, got kind %0d text %02h row %0d params %0d %0d"},
                     $realtime, results_seen, want.kind, want.text, want.row,
                     want.param1, want.param2, kind, text_byte, command_row,
                     param_first, param_second);
          mismatch_cnt++;
        end
      end
    end
  end

endmodule
